### rtl/asf_pkg.sv
// Shared types and constants of the angle spring follower.
// Used by every module of the block but asf_div; depends on nothing.
package asf_pkg;

  // Defaults for the top-level parameters
  localparam int SUBSTEP_MS_DEF      = 5;
  localparam int SPEED_FRAC_BITS_DEF = 8;

  // Configuration port
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_GAP     = 3'd0,
    REG_SPRING      = 3'd1,
    REG_DAMPING     = 3'd2,
    REG_EXTRA_DAMP  = 3'd3,
    REG_FRICTION    = 3'd4,
    REG_SNAP_ANGLE  = 3'd5,
    REG_SNAP_SPEED  = 3'd6,
    REG_SPEED_CAP   = 3'd7
  } cfg_reg_t;

  localparam logic [15:0] MAX_GAP_RST    = 16'd500;
  localparam logic [27:0] SPRING_RST     = 28'd46603378;
  localparam logic [15:0] DAMPING_RST    = 16'd512;
  localparam logic [15:0] EXTRA_DAMP_RST = 16'd896;
  localparam logic [23:0] FRICTION_RST   = 24'd46603;
  localparam logic [14:0] SNAP_ANGLE_RST = 15'd46;
  localparam logic [23:0] SNAP_SPEED_RST = 24'd46603;
  localparam logic [30:0] SPEED_CAP_RST  = 31'd1398101333;

  // Datapath widths
  localparam int DIV_W      = 64;  // divider dividend and quotient
  localparam int V_W        = 51;  // working velocity inside a substep
  localparam int DAMP_MAG_W = 41;  // |v| feeding a damping product, at most 2^40

  // Channel words
  typedef struct packed {
    logic [30:0] time_ms;
    logic [15:0] view_yaw;
    logic [15:0] north_yaw;
  } item_t;

  typedef struct packed {
    logic [15:0] shown_angle;
    logic        resynced;
    logic        settled;
  } result_t;

  // Datapath commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_STEP,
    OP_SNAP,
    OP_FINISH,
    OP_SPR_GO,
    OP_SPR_TAKE,
    OP_FRC_GO,
    OP_FRC_TAKE,
    OP_ERR_GO,
    OP_ERR_TAKE,
    OP_SPRING,
    OP_MUL1,
    OP_D1_GO,
    OP_D1_TAKE,
    OP_MUL2,
    OP_D2_GO,
    OP_D2_TAKE,
    OP_FRIC,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic resync_hit;
    logic rem_zero;
    logic snap_hit;
    logic terms_hit;
    logic extra_damp;
    logic div_done;
  } dp_status_t;

endpackage

### rtl/asf_div.sv
// Unsigned divide by 1000 of the angle spring follower, one 16-bit quotient
// digit a cycle by reciprocal multiplication. No package use.
module asf_div #(
  parameter int DIVIDEND_W = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  done
);

  // DIVIDEND_W is a multiple of 16
  localparam int DIGITS = DIVIDEND_W / 16;
  localparam int CNT_W  = $clog2(DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);
  // floor(n/1000) = (n*RECIP) >> 36 for every n below 1000*2^16
  localparam logic [26:0] RECIP   = 27'd68719477;
  localparam logic [25:0] DIVISOR = 26'd1000;

  logic [DIVIDEND_W-1:0] acc;
  logic [9:0]            rem;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic [25:0]           part;
  logic [52:0]           prod;
  logic [15:0]           digit;
  logic [9:0]            rem_next;

  // One digit step: remainder and next dividend digit, divided by 1000
  assign part     = {rem, acc[DIVIDEND_W-1 -: 16]};
  assign prod     = part * RECIP;
  assign digit    = prod[51:36];
  assign rem_next = 10'(part - (26'(digit) * DIVISOR));

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift register: dividend digits out, quotient digits in
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
    end else if (busy) begin
      acc <= {acc[DIVIDEND_W-17:0], digit};
      rem <= rem_next;
    end
  end

  assign quotient = acc;

endmodule

### rtl/asf_dp.sv
// Datapath of the angle spring follower: registers, state, arithmetic.
// Uses asf_pkg and the shared divider asf_div.
module asf_dp #(
  parameter int SUBSTEP_MS      = asf_pkg::SUBSTEP_MS_DEF,
  parameter int SPEED_FRAC_BITS = asf_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [asf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asf_pkg::CFG_W-1:0]      cfg_data,
  input  asf_pkg::item_t                 item,
  input  asf_pkg::dp_cmd_t               cmd,
  output asf_pkg::dp_status_t            status,
  output asf_pkg::result_t               result
);
  import asf_pkg::*;

  localparam int STEP_W = $clog2(SUBSTEP_MS + 1);
  localparam int K_W    = 10 + SPEED_FRAC_BITS;
  localparam int PROD_W = DAMP_MAG_W + 16;
  localparam logic [K_W-1:0]    DIV_K     = K_W'(1000) << SPEED_FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_FULL = STEP_W'(SUBSTEP_MS);
  localparam logic signed [V_W-1:0] MID_POS = V_W'(64'h100_0000_0000);
  localparam logic signed [V_W-1:0] MID_NEG = -MID_POS;

  // Configuration registers
  logic [15:0] max_gap;
  logic [27:0] spring;
  logic [15:0] damping;
  logic [15:0] extra_damp;
  logic [23:0] friction;
  logic [14:0] snap_angle;
  logic [23:0] snap_speed;
  logic [30:0] speed_cap;

  // Persistent state
  logic [31:0]        last_time;
  logic [15:0]        angle;
  logic signed [31:0] speed;

  // Per-item working registers
  logic [30:0]           now;
  logic [15:0]           target;
  logic signed [16:0]    err;
  logic signed [V_W-1:0] v;
  logic [15:0]           rem;
  logic [STEP_W-1:0]     step;
  logic [STEP_W-1:0]     term_step;
  logic                  terms_ok;
  logic [27:0]           spring_t;
  logic [23:0]           fric_t;
  logic [PROD_W-1:0]     prod;
  logic                  neg;
  logic                  vpos;
  result_t               pend;

  // Divider hookup; the divider always divides by 1000, a scale of
  // 1000*2^F is a shift by F first
  logic              div_start;
  logic [DIV_W-1:0]  div_a;
  logic [DIV_W-1:0]  div_q;
  logic              div_done;

  asf_div #(
    .DIVIDEND_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .quotient (div_q),
    .done     (div_done)
  );

  // Combinational helpers
  logic signed [33:0]    gap;
  logic                  resync_hit;
  logic [STEP_W-1:0]     step_calc;
  logic [16:0]           err_abs;
  logic [V_W-1:0]        v_abs;
  logic                  err_pos;
  logic                  err_neg;
  logic signed [17:0]    diff;
  logic signed [16:0]    err_init;
  logic signed [63:0]    num;
  logic [63:0]           num_abs;
  logic signed [V_W-1:0] q_s;
  logic signed [V_W-1:0] v_d1;
  logic signed [V_W-1:0] v_fr;
  logic signed [V_W-1:0] v_fric;
  logic signed [V_W-1:0] capv;
  logic [15:0]           e16;
  logic [15:0]           angle_fin;

  assign gap = $signed({3'b000, now}) - $signed({{2{last_time[31]}}, last_time});
  assign resync_hit = gap[33] || (gap > $signed({18'd0, max_gap}));
  assign step_calc  = (rem > 16'(SUBSTEP_MS)) ? STEP_FULL : rem[STEP_W-1:0];
  assign err_abs    = err[16] ? 17'(-err) : 17'(err);
  assign v_abs      = v[V_W-1] ? V_W'(-v) : V_W'(v);
  assign err_neg    = err[16];
  assign err_pos    = !err[16] && (err != 17'sd0);
  assign capv       = $signed(V_W'(speed_cap));
  assign angle_fin  = err[15:0] + target;

  // Initial error, wrapped to half a turn either way
  always_comb begin
    diff = $signed({2'b00, angle}) - $signed({2'b00, target});
    if (diff > 18'sd32768) begin
      err_init = 17'(diff - 18'sd65536);
    end else if (diff < -18'sd32768) begin
      err_init = 17'(diff + 18'sd65536);
    end else begin
      err_init = 17'(diff);
    end
  end

  // Error update numerator err*K + v*step, as sign and magnitude
  always_comb begin
    num     = 64'($signed(err)) * 64'($signed({1'b0, DIV_K}))
            + 64'($signed(v)) * 64'($signed({1'b0, step}));
    num_abs = num[63] ? 64'(-num) : 64'(num);
  end

  // Signed damping quotient and error quotient
  assign q_s = neg ? -$signed({1'b0, div_q[V_W-2:0]}) : $signed({1'b0, div_q[V_W-2:0]});
  assign e16 = neg ? 16'(-div_q[15:0]) : div_q[15:0];

  // First damping, then the mid-range clamp
  always_comb begin
    v_d1 = v - q_s;
    if (v_d1 > MID_POS) begin
      v_d1 = MID_POS;
    end else if (v_d1 < MID_NEG) begin
      v_d1 = MID_NEG;
    end
  end

  // Friction toward zero with zero-crossing clamp, then the speed cap
  always_comb begin
    if (vpos) begin
      v_fr = v - V_W'(fric_t);
      if (v_fr[V_W-1]) begin
        v_fric = '0;
      end else if (v_fr > capv) begin
        v_fric = capv;
      end else begin
        v_fric = v_fr;
      end
    end else begin
      v_fr = v + V_W'(fric_t);
      if (v_fr > 0) begin
        v_fric = '0;
      end else if (v_fr < -capv) begin
        v_fric = -capv;
      end else begin
        v_fric = v_fr;
      end
    end
  end

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    case (cmd.op)
      OP_SPR_GO: begin
        div_start = 1'b1;
        div_a     = 64'(spring) * 64'(step);
      end
      OP_FRC_GO: begin
        div_start = 1'b1;
        div_a     = 64'(friction) * 64'(step);
      end
      OP_ERR_GO: begin
        div_start = 1'b1;
        div_a     = num_abs >> SPEED_FRAC_BITS;
      end
      OP_D1_GO, OP_D2_GO: begin
        div_start = 1'b1;
        div_a     = (64'(prod) * 64'(step)) >> SPEED_FRAC_BITS;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap    <= MAX_GAP_RST;
      spring     <= SPRING_RST;
      damping    <= DAMPING_RST;
      extra_damp <= EXTRA_DAMP_RST;
      friction   <= FRICTION_RST;
      snap_angle <= SNAP_ANGLE_RST;
      snap_speed <= SNAP_SPEED_RST;
      speed_cap  <= SPEED_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_GAP:    max_gap    <= cfg_data[15:0];
        REG_SPRING:     spring     <= cfg_data[27:0];
        REG_DAMPING:    damping    <= cfg_data[15:0];
        REG_EXTRA_DAMP: extra_damp <= cfg_data[15:0];
        REG_FRICTION:   friction   <= cfg_data[23:0];
        REG_SNAP_ANGLE: snap_angle <= cfg_data[14:0];
        REG_SNAP_SPEED: snap_speed <= cfg_data[23:0];
        REG_SPEED_CAP:  speed_cap  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Follower state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= 32'hFFFF_FFFF;
      angle     <= '0;
      speed     <= '0;
      terms_ok  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CHECK: begin
          last_time <= {1'b0, now};
          terms_ok  <= 1'b0;
          if (resync_hit) begin
            angle <= target;
            speed <= '0;
          end
        end
        OP_STEP: begin
          if (!(terms_ok && step_calc == term_step)) begin
            terms_ok <= 1'b0;
          end
        end
        OP_FRC_TAKE: terms_ok <= 1'b1;
        OP_SNAP: begin
          angle <= target;
          speed <= '0;
        end
        OP_FINISH: begin
          angle <= angle_fin;
          speed <= v[31:0];
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        now    <= item.time_ms;
        target <= item.view_yaw - item.north_yaw;
      end
      OP_CHECK: begin
        err  <= err_init;
        v    <= V_W'(speed);
        rem  <= gap[15:0];
        pend <= '{shown_angle: target, resynced: 1'b1, settled: 1'b0};
      end
      OP_STEP: begin
        step <= step_calc;
        rem  <= rem - 16'(step_calc);
      end
      OP_SNAP:   pend <= '{shown_angle: target, resynced: 1'b0, settled: 1'b1};
      OP_FINISH: pend <= '{shown_angle: angle_fin, resynced: 1'b0, settled: 1'b0};
      OP_SPR_GO:   term_step <= step;
      OP_SPR_TAKE: spring_t  <= div_q[27:0];
      OP_FRC_TAKE: fric_t    <= div_q[23:0];
      OP_ERR_GO:   neg <= num[63];
      OP_ERR_TAKE: err <= (e16 > 16'd32768) ? $signed({1'b1, e16}) : $signed({1'b0, e16});
      OP_SPRING: begin
        if (err_pos) begin
          v <= v - V_W'(spring_t);
        end else if (err_neg) begin
          v <= v + V_W'(spring_t);
        end
      end
      OP_MUL1: prod <= v_abs[DAMP_MAG_W-1:0] * damping;
      OP_MUL2: prod <= v_abs[DAMP_MAG_W-1:0] * extra_damp;
      OP_D1_GO, OP_D2_GO: neg <= v[V_W-1];
      OP_D1_TAKE: begin
        v    <= v_d1;
        vpos <= !v_d1[V_W-1] && (v_d1 != '0);
      end
      OP_D2_TAKE: v <= v - q_s;
      OP_FRIC:    v <= v_fric;
      OP_EMIT:    result <= pend;
      default: ;
    endcase
  end

  // Status to the controller
  assign status.resync_hit = resync_hit;
  assign status.rem_zero   = (rem == 16'd0);
  assign status.snap_hit   = (err_abs < {2'b00, snap_angle}) && (v_abs < V_W'(snap_speed));
  assign status.terms_hit  = terms_ok && (step_calc == term_step);
  assign status.extra_damp = vpos ? err_pos : err_neg;
  assign status.div_done   = div_done;

endmodule

### rtl/asf_ctrl.sv
// Controller of the angle spring follower: sequences one item through the
// datapath and owns both channel handshakes. Uses asf_pkg.
module asf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  asf_pkg::dp_status_t  status,
  output asf_pkg::dp_cmd_t     cmd
);
  import asf_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_CHECK    = 19'h00002,
    S_LOOP     = 19'h00004,
    S_SPR_GO   = 19'h00008,
    S_SPR_WAIT = 19'h00010,
    S_FRC_GO   = 19'h00020,
    S_FRC_WAIT = 19'h00040,
    S_ERR_GO   = 19'h00080,
    S_ERR_WAIT = 19'h00100,
    S_SPRING   = 19'h00200,
    S_MUL1     = 19'h00400,
    S_D1_GO    = 19'h00800,
    S_D1_WAIT  = 19'h01000,
    S_D2_CHK   = 19'h02000,
    S_D2_GO    = 19'h04000,
    S_D2_WAIT  = 19'h08000,
    S_FRIC     = 19'h10000,
    S_OUT      = 19'h20000,
    S_SPARE    = 19'h40000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == S_IDLE);

  // Next state and command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op     = OP_CHECK;
        state_next = status.resync_hit ? S_OUT : S_LOOP;
      end
      S_LOOP: begin
        if (status.rem_zero) begin
          cmd.op     = OP_FINISH;
          state_next = S_OUT;
        end else if (status.snap_hit) begin
          cmd.op     = OP_SNAP;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_STEP;
          state_next = status.terms_hit ? S_ERR_GO : S_SPR_GO;
        end
      end
      S_SPR_GO: begin
        cmd.op     = OP_SPR_GO;
        state_next = S_SPR_WAIT;
      end
      S_SPR_WAIT: begin
        if (status.div_done) begin
          cmd.op     = OP_SPR_TAKE;
          state_next = S_FRC_GO;
        end
      end
      S_FRC_GO: begin
        cmd.op     = OP_FRC_GO;
        state_next = S_FRC_WAIT;
      end
      S_FRC_WAIT: begin
        if (status.div_done) begin
          cmd.op     = OP_FRC_TAKE;
          state_next = S_ERR_GO;
        end
      end
      S_ERR_GO: begin
        cmd.op     = OP_ERR_GO;
        state_next = S_ERR_WAIT;
      end
      S_ERR_WAIT: begin
        if (status.div_done) begin
          cmd.op     = OP_ERR_TAKE;
          state_next = S_SPRING;
        end
      end
      S_SPRING: begin
        cmd.op     = OP_SPRING;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.op     = OP_MUL1;
        state_next = S_D1_GO;
      end
      S_D1_GO: begin
        cmd.op     = OP_D1_GO;
        state_next = S_D1_WAIT;
      end
      S_D1_WAIT: begin
        if (status.div_done) begin
          cmd.op     = OP_D1_TAKE;
          state_next = S_D2_CHK;
        end
      end
      S_D2_CHK: begin
        if (status.extra_damp) begin
          cmd.op     = OP_MUL2;
          state_next = S_D2_GO;
        end else begin
          cmd.op     = OP_FRIC;
          state_next = S_LOOP;
        end
      end
      S_D2_GO: begin
        cmd.op     = OP_D2_GO;
        state_next = S_D2_WAIT;
      end
      S_D2_WAIT: begin
        if (status.div_done) begin
          cmd.op     = OP_D2_TAKE;
          state_next = S_FRIC;
        end
      end
      S_FRIC: begin
        cmd.op     = OP_FRIC;
        state_next = S_LOOP;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_EMIT) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/angle_spring_follower_unit.sv
// Angle spring follower: smooths a displayed heading toward view yaw minus
// north yaw like a damped spring integrated in fixed millisecond substeps.
//
// Input channel item/item_valid/item_ready takes one word per item: a time
// stamp and two binary angles. Output channel result/result_valid/
// result_ready gives one word per item: the shown angle and the resync and
// settle flags. cfg_we/cfg_index/cfg_data write the eight setup registers.
//
// Items are worked one at a time. A resync passes the states CHECK and OUT, a zero
// gap CHECK, LOOP and OUT, and the next word can be taken in the cycle that the
// result first shows valid. Otherwise the item runs n = ceil(gap/SUBSTEP_MS)
// substeps with two or three divisions each in the shared divide-by-1000 unit
// (three when the extra damping applies), plus two more where the spring and
// friction steps are worked out again (first substep and a shorter last one); a
// snap ends the item early.
//
// Reset restores the register defaults and a last time of minus one, so the
// first item either resyncs or integrates from angle zero. The finished word
// waits in an output register while the next item is taken and worked; a
// stalled receiver holds the block only once that next result is ready.
module angle_spring_follower_unit #(
  parameter int SUBSTEP_MS      = asf_pkg::SUBSTEP_MS_DEF,
  parameter int SPEED_FRAC_BITS = asf_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [asf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asf_pkg::CFG_W-1:0]     cfg_data,
  input  asf_pkg::item_t                item,
  input  logic                          item_valid,
  output logic                          item_ready,
  output asf_pkg::result_t              result,
  output logic                          result_valid,
  input  logic                          result_ready
);
  import asf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  asf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  asf_dp #(
    .SUBSTEP_MS      (SUBSTEP_MS),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  // A quotient is only taken once the divider reports it
  a_take_after_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SPR_TAKE || cmd.op == OP_FRC_TAKE || cmd.op == OP_ERR_TAKE ||
     cmd.op == OP_D1_TAKE || cmd.op == OP_D2_TAKE) |-> status.div_done)
    else $error("divider result taken before done");

  // One item in flight: no second word right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("input taken while an item is in flight");

  // Divider finishes only while an item is worked
  a_div_in_item: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> !item_ready)
    else $error("divider done while idle");

  // Resync and settle never come together
  a_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.resynced && result.settled))
    else $error("resynced and settled both set");

endmodule

### sim/angle_spring_follower_unit_tb.sv
// Self-checking testbench for angle_spring_follower_unit.
// Uses asf_pkg for the word types and register indexes. A built-in damped-spring
// predictor checks every unpinned result, under several register settings and idle patterns.
`timescale 1ns / 100ps

module angle_spring_follower_unit_tb;
  import asf_pkg::*;

  localparam int    STEP_MS  = SUBSTEP_MS_DEF;
  localparam longint SCALE   = 1000 * (longint'(1) << SPEED_FRAC_BITS_DEF);
  localparam longint V_LIMIT = longint'(1) << 40;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  item_t                item;
  logic                 item_valid;
  logic                 item_ready;
  result_t              result;
  logic                 result_valid;
  logic                 result_ready;

  angle_spring_follower_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item(item), .item_valid(item_valid), .item_ready(item_ready),
    .result(result), .result_valid(result_valid), .result_ready(result_ready)
  );

  // Follower state and register copy
  logic [31:0] prev_time;
  logic [15:0] shown;
  longint      speed;
  longint      reg_val [8];

  result_t     angle_q [$];
  int          fail_count;
  int          taken_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          pin_on;
  result_t     pin_val;

  // Directed words; pinned rows carry a result typed in by hand
  typedef struct {
    logic [30:0] t;
    logic [15:0] view;
    logic [15:0] north;
    bit          pin;
    result_t     res;
  } row_t;

  row_t rows [] = '{
    '{31'd3,          16'h4000, 16'h0000, 0, '0},                    // integrate from reset
    '{31'd1000,       16'h1234, 16'h0234, 1, '{16'h1000, 1'b1, 1'b0}},
    '{31'd1000,       16'h1234, 16'h0234, 1, '{16'h1000, 1'b0, 1'b0}}, // zero gap
    '{31'd1005,       16'h1234, 16'h0234, 1, '{16'h1000, 1'b0, 1'b1}}, // snap
    '{31'd1010,       16'h9000, 16'h1000, 0, '0},
    '{31'd1510,       16'hFFFF, 16'h0000, 0, '0},                    // gap at limit
    '{31'd2011,       16'hFFFF, 16'h0000, 1, '{16'hFFFF, 1'b1, 1'b0}}, // gap over limit
    '{31'd2000,       16'h0000, 16'hFFFF, 1, '{16'h0001, 1'b1, 1'b0}}, // time backwards
    '{31'h7FFFFFFF,   16'h5555, 16'hAAAA, 1, '{16'hAAAB, 1'b1, 1'b0}},
    '{31'd0,          16'hAAAA, 16'h5555, 1, '{16'h5555, 1'b1, 1'b0}},
    '{31'd7,          16'h8000, 16'h0000, 0, '0},
    '{31'd20000,      16'h0000, 16'h0000, 1, '{16'h0000, 1'b1, 1'b0}},
    '{31'd20003,      16'h8000, 16'h0000, 0, '0},                    // half-turn error
    '{31'd20010,      16'h8001, 16'h0001, 0, '0},
    '{31'd20013,      16'h7FFF, 16'hFFFF, 0, '0},
    '{31'd20100,      16'h1111, 16'h2222, 0, '0}
  };

  function automatic longint wrap_half(longint x);
    longint u;
    u = x & 64'hFFFF;
    return (u > 32768) ? u - 65536 : u;
  endfunction

  function automatic longint damping(longint v, longint rate, longint dt);
    return (v * rate * dt) / SCALE;
  endfunction

  function automatic longint absval(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Damped-spring follower: one word in, one result out
  function automatic result_t follow_step(item_t w);
    longint      now, last, gap, err, v, dt, fric;
    logic [15:0] tgt;
    result_t     r;
    now  = w.time_ms;
    tgt  = w.view_yaw - w.north_yaw;
    last = longint'($signed(prev_time));
    gap  = now - last;
    r    = '0;
    prev_time = now[31:0];
    if (last > now || gap > reg_val[REG_MAX_GAP]) begin
      shown = tgt;
      speed = 0;
      r.shown_angle = tgt;
      r.resynced = 1'b1;
      return r;
    end
    err = longint'(shown) - longint'(tgt);
    if (err > 32768) err -= 65536;
    if (err < -32768) err += 65536;
    v = speed;
    while (gap > 0) begin
      dt = (gap > STEP_MS) ? STEP_MS : gap;
      gap -= dt;
      if (absval(err) < reg_val[REG_SNAP_ANGLE] && absval(v) < reg_val[REG_SNAP_SPEED]) begin
        speed = 0;
        shown = tgt;
        r.shown_angle = tgt;
        r.settled = 1'b1;
        return r;
      end
      err = wrap_half((v * dt + err * SCALE) / SCALE);
      if (err > 0) v -= (reg_val[REG_SPRING] * dt) / 1000;
      else if (err < 0) v += (reg_val[REG_SPRING] * dt) / 1000;
      v -= damping(v, reg_val[REG_DAMPING], dt);
      if (v > V_LIMIT) v = V_LIMIT;
      if (v < -V_LIMIT) v = -V_LIMIT;
      fric = (reg_val[REG_FRICTION] * dt) / 1000;
      if (v > 0) begin
        if (err > 0) v -= damping(v, reg_val[REG_EXTRA_DAMP], dt);
        v -= fric;
        if (v < 0) begin
          v = 0;
          continue;
        end
      end else begin
        if (err < 0) v -= damping(v, reg_val[REG_EXTRA_DAMP], dt);
        v += fric;
        if (v > 0) begin
          v = 0;
          continue;
        end
      end
      if (v > reg_val[REG_SPEED_CAP]) v = reg_val[REG_SPEED_CAP];
      else if (v < -reg_val[REG_SPEED_CAP]) v = -reg_val[REG_SPEED_CAP];
    end
    speed = v;
    shown = 16'(err + 65536 + longint'(tgt));
    r.shown_angle = shown;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Accepted words on both channels
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && item_valid && item_ready) begin
      exp_r = follow_step(item);
      angle_q.push_back(pin_on ? pin_val : exp_r);
      taken_count++;
    end
    if (!rst && result_valid && result_ready) begin
      if (angle_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        exp_r = angle_q.pop_front();
        if (result.shown_angle !== exp_r.shown_angle)
          report_mismatch($sformatf("shown_angle %h, want %h",
                                    result.shown_angle, exp_r.shown_angle));
        if (result.resynced !== exp_r.resynced)
          report_mismatch($sformatf("resynced %b, want %b", result.resynced, exp_r.resynced));
        if (result.settled !== exp_r.settled)
          report_mismatch($sformatf("settled %b, want %b", result.settled, exp_r.settled));
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk)
    result_ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic write_reg(cfg_reg_t idx, longint val);
    longint masks [8] = '{64'hFFFF, 64'hFFFFFFF, 64'hFFFF, 64'hFFFF,
                          64'hFFFFFF, 64'h7FFF, 64'hFFFFFF, 64'h7FFFFFFF};
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val & masks[idx]);
    reg_val[idx] = val & masks[idx];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(item_t w, bit pin, result_t pexp);
    int n0;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    n0 = taken_count;
    item       <= w;
    item_valid <= 1'b1;
    pin_on     <= pin;
    pin_val    <= pexp;
    @(negedge clk);
    while (taken_count == n0) @(negedge clk);
  endtask

  task automatic drain;
    item_valid <= 1'b0;
    while (angle_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // Stimulus
  initial begin
    item_t       w;
    logic [30:0] t;
    logic [15:0] tgt;
    longint      gap, gap_top;
    int          k;
    fail_count = 0;
    taken_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pin_on = 1'b0;
    pin_val = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item = '0;
    item_valid = 1'b0;
    prev_time = 32'hFFFFFFFF;
    shown = '0;
    speed = 0;
    reg_val = '{MAX_GAP_RST, SPRING_RST, DAMPING_RST, EXTRA_DAMP_RST,
                FRICTION_RST, SNAP_ANGLE_RST, SNAP_SPEED_RST, SPEED_CAP_RST};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (rows[i]) begin
      w.time_ms = rows[i].t;
      w.view_yaw = rows[i].view;
      w.north_yaw = rows[i].north;
      send_word(w, rows[i].pin, rows[i].res);
    end
    drain();

    // Random phases under several register settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 5: begin
          write_reg(REG_MAX_GAP, MAX_GAP_RST);     write_reg(REG_SPRING, SPRING_RST);
          write_reg(REG_DAMPING, DAMPING_RST);     write_reg(REG_EXTRA_DAMP, EXTRA_DAMP_RST);
          write_reg(REG_FRICTION, FRICTION_RST);   write_reg(REG_SNAP_ANGLE, SNAP_ANGLE_RST);
          write_reg(REG_SNAP_SPEED, SNAP_SPEED_RST); write_reg(REG_SPEED_CAP, SPEED_CAP_RST);
        end
        1: begin
          // all-zero corner; short gap limit keeps some integration
          for (int r = 0; r < 8; r++) write_reg(cfg_reg_t'(r), 0);
          write_reg(REG_MAX_GAP, (ph == 1) ? 40 : 0);
        end
        2: begin
          for (int r = 0; r < 8; r++) write_reg(cfg_reg_t'(r), -1);
        end
        default: begin
          for (int r = 0; r < 8; r++) write_reg(cfg_reg_t'(r), {$urandom(), $urandom()});
          write_reg(REG_MAX_GAP, $urandom_range(600));
          write_reg(REG_SNAP_ANGLE, $urandom_range(200));
          write_reg(REG_SNAP_SPEED, $urandom_range(200000));
        end
      endcase
      if (ph == 4) write_reg(REG_MAX_GAP, 0);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      gap_top = (reg_val[REG_MAX_GAP] < 500) ? reg_val[REG_MAX_GAP] : 500;
      t = 31'($urandom());
      tgt = 16'($urandom());
      for (int n = 0; n < 195; n++) begin
        k = $urandom_range(99);
        if (k < 4) begin
          t = 31'($urandom());                      // jump, often backwards
        end else begin
          if (k < 8) gap = 0;
          else if (k < 11) gap = $urandom_range(gap_top);
          else if (k < 14) gap = reg_val[REG_MAX_GAP] + 1 + $urandom_range(1000);
          else if (k < 25) gap = $urandom_range(60);
          else gap = $urandom_range(20, 1);
          t = t + 31'(gap);
        end
        // mostly a slowly drifting heading, sometimes a fresh one
        if ($urandom_range(99) < 25) tgt = 16'($urandom());
        else tgt = tgt + 16'($urandom_range(400)) - 16'd200;
        w.time_ms = t;
        w.north_yaw = 16'($urandom());
        w.view_yaw = tgt + w.north_yaw;
        send_word(w, 1'b0, '0);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

endmodule
